// ===== src/looping_sample_player_cubic_defines.svh =====
// -----------------------------------------------------------------------------
// Assertion macros for the looping sample player
// Shared property forms used by the port checker.
// -----------------------------------------------------------------------------
`ifndef LOOPING_SAMPLE_PLAYER_CUBIC_DEFINES_SVH
`define LOOPING_SAMPLE_PLAYER_CUBIC_DEFINES_SVH

// Same-cycle implication, off during reset
`define LSPC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lspc check failed");

// Next-cycle implication, off during reset
`define LSPC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lspc check failed");

// Implication that also holds while reset is asserted
`define LSPC_ASSERT_ALWAYS(label, ante, cons) \
    label: assert property (@(posedge clk) (ante) |-> (cons)) \
        else $error("lspc check failed");

`endif

// ===== src/lspc_pkg.sv =====
// -----------------------------------------------------------------------------
// lspc_pkg
// Types and fixed constants of the looping sample player.
// -----------------------------------------------------------------------------
package lspc_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int FRAC_W     = 16;
    localparam int POS_W      = 17 + FRAC_W;
    localparam int LEN_W      = 17;
    localparam int RATE_W     = 19;
    localparam int ADDR_W     = 16;
    localparam int SEEK_W     = 32;
    localparam int NUM_W      = 18;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int Q_DEPTH    = 2;

    localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(65536);
    localparam logic [LEN_W-1:0]  LEN_RESET  = LEN_W'(4);
    localparam logic [LEN_W-1:0]  LEN_MIN    = LEN_W'(4);

    localparam logic [CFG_IDX_W-1:0] REG_RATE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOOP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEREO = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MONO   = 3'd4;

    typedef enum logic [2:0] {
        OP_WRITE = 3'd0,
        OP_TICK  = 3'd1,
        OP_PLAY  = 3'd2,
        OP_STOP  = 3'd3,
        OP_SEEK  = 3'd4
    } op_t;

    typedef struct packed {
        op_t                        op;
        logic                       channel;
        logic [ADDR_W-1:0]          address;
        logic signed [SAMPLE_W-1:0] sample_value;
        logic [SEEK_W-1:0]          seek_position;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } push_t;

    typedef struct packed {
        logic [RATE_W-1:0] rate;
        logic [LEN_W-1:0]  len;
        logic              loop_en;
        logic              stereo;
        logic              mono;
    } cfg_t;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [LEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [LEN_W-1:0] rem;
    } div_rsp_t;

endpackage

// ===== src/lspc_front.sv =====
// -----------------------------------------------------------------------------
// lspc_front
// Input side: accept items, decode the kind, drop unused kinds.
// -----------------------------------------------------------------------------
module lspc_front (
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [2:0]                          kind,
    input  logic                                channel,
    input  logic [lspc_pkg::ADDR_W-1:0]         address,
    input  logic signed [lspc_pkg::SAMPLE_W-1:0] sample_value,
    input  logic [lspc_pkg::SEEK_W-1:0]         seek_position,
    input  logic                                q_full,
    output lspc_pkg::push_t                     push
);

    logic known;

    always_comb
    begin
        case (kind)
            lspc_pkg::OP_WRITE, lspc_pkg::OP_TICK, lspc_pkg::OP_PLAY,
            lspc_pkg::OP_STOP, lspc_pkg::OP_SEEK: known = 1'b1;
            default:                              known = 1'b0;
        endcase
    end

    assign in_stall = q_full;

    always_comb
    begin
        push.valid              = in_valid && !q_full && known;
        push.cmd.op             = lspc_pkg::op_t'(kind);
        push.cmd.channel        = channel;
        push.cmd.address        = address;
        push.cmd.sample_value   = sample_value;
        push.cmd.seek_position  = seek_position;
    end

endmodule

// ===== src/lspc_queue.sv =====
// -----------------------------------------------------------------------------
// lspc_queue
// Short command queue between the front and the back.
// -----------------------------------------------------------------------------
module lspc_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  lspc_pkg::push_t push,
    input  logic            pop,
    output logic            full,
    output logic            empty,
    output lspc_pkg::cmd_t  head
);

    localparam int PTR_W = $clog2(lspc_pkg::Q_DEPTH);
    localparam int CNT_W = $clog2(lspc_pkg::Q_DEPTH + 1);

    lspc_pkg::cmd_t   slot_reg [lspc_pkg::Q_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_pop;

    assign full   = (count_reg == CNT_W'(lspc_pkg::Q_DEPTH));
    assign empty  = (count_reg == '0);
    assign head   = slot_reg[rd_ptr_reg];
    assign do_pop = pop && !empty;

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            slot_reg[wr_ptr_reg] <= push.cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push.valid)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(lspc_pkg::Q_DEPTH - 1)) ? '0
                                                                             : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(lspc_pkg::Q_DEPTH - 1)) ? '0
                                                                             : rd_ptr_reg + 1'b1;
            end
            if (push.valid && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (!push.valid && do_pop)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== src/lspc_rem.sv =====
// -----------------------------------------------------------------------------
// lspc_rem
// Bit-serial remainder unit: one dividend bit per cycle.
// -----------------------------------------------------------------------------
module lspc_rem (
    input  logic               clk,
    input  logic               rst_n,
    input  lspc_pkg::div_req_t req,
    output lspc_pkg::div_rsp_t rsp
);

    localparam int CNT_W = $clog2(lspc_pkg::NUM_W + 1);

    logic [lspc_pkg::NUM_W-1:0] num_reg;
    logic [lspc_pkg::LEN_W-1:0] den_reg;
    logic [lspc_pkg::LEN_W-1:0] rem_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;
    logic [lspc_pkg::LEN_W:0]   trial;

    assign trial    = {rem_reg, num_reg[lspc_pkg::NUM_W-1]};
    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            num_reg  <= '0;
            den_reg  <= '0;
            rem_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                num_reg  <= req.num;
                den_reg  <= req.den;
                rem_reg  <= '0;
                cnt_reg  <= CNT_W'(lspc_pkg::NUM_W);
            end
            else if (busy_reg)
            begin
                // shift in the next dividend bit, subtract when it fits
                if (trial >= {1'b0, den_reg})
                begin
                    rem_reg <= lspc_pkg::LEN_W'(trial - {1'b0, den_reg});
                end
                else
                begin
                    rem_reg <= lspc_pkg::LEN_W'(trial);
                end
                num_reg <= {num_reg[lspc_pkg::NUM_W-2:0], 1'b0};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

// ===== src/lspc_back.sv =====
// -----------------------------------------------------------------------------
// lspc_back
// Execution side: sample memory, cubic interpolation, position update.
// -----------------------------------------------------------------------------
module lspc_back #(
    parameter int MEM_DEPTH = 65536
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  lspc_pkg::cfg_t                       cfg,
    input  logic                                 q_empty,
    input  lspc_pkg::cmd_t                       q_head,
    output logic                                 q_pop,
    output lspc_pkg::div_req_t                   div_req,
    input  lspc_pkg::div_rsp_t                   div_rsp,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [lspc_pkg::SAMPLE_W-1:0] out_left,
    output logic signed [lspc_pkg::SAMPLE_W-1:0] out_right,
    output logic                                 still_running,
    output logic [lspc_pkg::POS_W-1:0]           position_now
);

    localparam int IDX_W   = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int MEM_W   = IDX_W + 1;
    localparam int SW      = lspc_pkg::SAMPLE_W;
    localparam int FW      = lspc_pkg::FRAC_W;
    localparam int LW      = lspc_pkg::LEN_W;
    localparam int PW      = lspc_pkg::POS_W;
    localparam int ACC_W   = 24;
    localparam int PROD_W  = ACC_W + FW + 1;
    localparam int X6_W    = 24;
    localparam int M6_W    = 24;
    localparam int Q6_W    = X6_W + M6_W;
    localparam int SH6     = 26;
    localparam int BIAS6   = 1 << 20;
    localparam int OFS6    = 6 * BIAS6 + 3;
    localparam logic [M6_W-1:0] MUL6 = M6_W'(11184811);
    localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) <<< (FW - 1);
    localparam logic signed [ACC_W-1:0]  SMAX = ACC_W'((1 << (SW - 1)) - 1);
    localparam logic signed [ACC_W-1:0]  SMIN = -ACC_W'(1 << (SW - 1));

    typedef enum logic [3:0] {
        ST_IDLE, ST_SEEK, ST_INDEX, ST_READ, ST_COEF, ST_MUL, ST_RND,
        ST_DIV6, ST_FIN, ST_ADV, ST_WRAP, ST_OUT
    } state_t;

    logic signed [SW-1:0] mem [2**MEM_W];

    state_t                     state_reg;
    lspc_pkg::cmd_t             cmd_reg;
    logic                       running_reg;
    logic [PW-1:0]              pos_reg;
    logic [PW:0]                newpos_reg;
    logic [IDX_W-1:0]           idx_reg [4];
    logic                       ch_reg;
    logic [2:0]                 rd_cnt_reg;
    logic signed [SW-1:0]       rdata_reg;
    logic signed [SW-1:0]       y_reg [4];
    logic signed [ACC_W-1:0]    a_reg, b_reg, c_reg, t_reg;
    logic [1:0]                 step_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic [Q6_W-1:0]            q6_reg;
    logic signed [SW-1:0]       l_reg, r_reg;
    logic                       div_start_reg;
    logic [lspc_pkg::NUM_W-1:0] div_num_reg;
    logic                       out_valid_reg;
    logic signed [SW-1:0]       out_left_reg, out_right_reg;
    logic                       out_run_reg;
    logic [PW-1:0]              out_pos_reg;

    logic                       wr_en;
    logic [MEM_W-1:0]           wr_addr;
    logic [MEM_W-1:0]           rd_addr;
    logic [LW-1:0]              im, m1, p1, p2;
    logic signed [ACC_W-1:0]    y0e, y1e, y2e, y3e, a_c, b_c, c_c, mul_op;
    logic signed [FW:0]         f_s;
    logic signed [PROD_W-1:0]   rnd_c;
    logic signed [ACC_W+1:0]    x6;
    logic signed [ACC_W-1:0]    q6, fin_v, fin_sat;
    logic signed [SW:0]         mix_sum;
    logic [PW:0]                adv_pos;
    logic                       can_load;

    // ---------------- sample memory ----------------
    assign wr_en   = (state_reg == ST_IDLE) && !q_empty && (q_head.op == lspc_pkg::OP_WRITE)
                     && (32'(q_head.address) < 32'(MEM_DEPTH));
    assign wr_addr = {q_head.channel, IDX_W'(q_head.address)};
    assign rd_addr = {ch_reg, idx_reg[rd_cnt_reg[1:0]]};

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= q_head.sample_value;
        end
        rdata_reg <= mem[rd_addr];
    end

    // ---------------- datapath helpers ----------------
    always_comb
    begin
        im = div_rsp.rem;
        m1 = (im == '0) ? cfg.len - 1'b1 : im - 1'b1;
        p1 = (im + 1'b1 == cfg.len) ? '0 : im + 1'b1;
        p2 = (p1 + 1'b1 == cfg.len) ? '0 : p1 + 1'b1;

        y0e = ACC_W'(y_reg[0]);
        y1e = ACC_W'(y_reg[1]);
        y2e = ACC_W'(y_reg[2]);
        y3e = ACC_W'(y_reg[3]);
        a_c = y3e - y0e + (y1e <<< 1) + y1e - (y2e <<< 1) - y2e;
        b_c = (y0e <<< 1) + y0e - (y1e <<< 2) - (y1e <<< 1) + (y2e <<< 1) + y2e;
        c_c = (y2e <<< 2) + (y2e <<< 1) - (y0e <<< 1) - (y1e <<< 1) - y1e - y3e;

        case (step_reg)
            2'd0:    mul_op = a_reg;
            2'd1:    mul_op = t_reg + b_reg;
            default: mul_op = t_reg + c_reg;
        endcase
        f_s   = $signed({1'b0, pos_reg[FW-1:0]});
        rnd_c = (prod_reg + HALF) >>> FW;

        x6      = (ACC_W+2)'(t_reg) + (ACC_W+2)'(OFS6);
        q6      = ACC_W'(q6_reg >> SH6) - ACC_W'(BIAS6);
        fin_v   = y1e + q6;
        fin_sat = (fin_v > SMAX) ? SMAX : ((fin_v < SMIN) ? SMIN : fin_v);

        mix_sum = (SW+1)'(l_reg) + (SW+1)'(r_reg);
        adv_pos = (PW+1)'(pos_reg) + (PW+1)'(cfg.rate);
        can_load = !out_valid_reg || !out_stall;
    end

    assign q_pop         = (state_reg == ST_IDLE) && !q_empty;
    assign div_req.start = div_start_reg;
    assign div_req.num   = div_num_reg;
    assign div_req.den   = cfg.len;

    assign out_valid     = out_valid_reg;
    assign out_left      = out_left_reg;
    assign out_right     = out_right_reg;
    assign still_running = out_run_reg;
    assign position_now  = out_pos_reg;

    // ---------------- sequencer ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            running_reg   <= 1'b0;
            pos_reg       <= '0;
            div_start_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
            rd_cnt_reg    <= '0;
            ch_reg        <= 1'b0;
        end
        else
        begin
            div_start_reg <= 1'b0;
            if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (!q_empty)
                    begin
                        cmd_reg <= q_head;
                        case (q_head.op)
                            lspc_pkg::OP_PLAY: running_reg <= 1'b1;
                            lspc_pkg::OP_STOP: running_reg <= 1'b0;
                            lspc_pkg::OP_SEEK:
                            begin
                                div_start_reg <= 1'b1;
                                div_num_reg   <= lspc_pkg::NUM_W'(q_head.seek_position[31:FW]);
                                state_reg     <= ST_SEEK;
                            end
                            lspc_pkg::OP_TICK:
                            begin
                                if (running_reg)
                                begin
                                    div_start_reg <= 1'b1;
                                    div_num_reg   <= lspc_pkg::NUM_W'(pos_reg[PW-1:FW]);
                                    state_reg     <= ST_INDEX;
                                end
                                else
                                begin
                                    l_reg     <= '0;
                                    r_reg     <= '0;
                                    state_reg <= ST_OUT;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_SEEK:
                begin
                    if (div_rsp.done)
                    begin
                        pos_reg   <= {div_rsp.rem, cmd_reg.seek_position[FW-1:0]};
                        state_reg <= ST_IDLE;
                    end
                end
                ST_INDEX:
                begin
                    if (div_rsp.done)
                    begin
                        idx_reg[0] <= IDX_W'(m1);
                        idx_reg[1] <= IDX_W'(im);
                        idx_reg[2] <= IDX_W'(p1);
                        idx_reg[3] <= IDX_W'(p2);
                        ch_reg     <= 1'b0;
                        rd_cnt_reg <= '0;
                        state_reg  <= ST_READ;
                    end
                end
                ST_READ:
                begin
                    // read data is registered and lands in the cycle after its address
                    if (rd_cnt_reg != '0)
                    begin
                        y_reg[2'(rd_cnt_reg - 1'b1)] <= rdata_reg;
                    end
                    rd_cnt_reg <= rd_cnt_reg + 1'b1;
                    if (rd_cnt_reg == 3'd4)
                    begin
                        state_reg <= ST_COEF;
                    end
                end
                ST_COEF:
                begin
                    a_reg     <= a_c;
                    b_reg     <= b_c;
                    c_reg     <= c_c;
                    step_reg  <= '0;
                    state_reg <= ST_MUL;
                end
                ST_MUL:
                begin
                    prod_reg  <= mul_op * f_s;
                    state_reg <= ST_RND;
                end
                ST_RND:
                begin
                    t_reg    <= ACC_W'(rnd_c);
                    step_reg <= step_reg + 1'b1;
                    state_reg <= (step_reg == 2'd2) ? ST_DIV6 : ST_MUL;
                end
                ST_DIV6:
                begin
                    // floor((t+3)/6) by reciprocal on a biased, non-negative value
                    q6_reg    <= X6_W'(x6) * MUL6;
                    state_reg <= ST_FIN;
                end
                ST_FIN:
                begin
                    if (!ch_reg)
                    begin
                        l_reg <= SW'(fin_sat);
                        r_reg <= SW'(fin_sat);
                        if (cfg.stereo)
                        begin
                            ch_reg     <= 1'b1;
                            rd_cnt_reg <= '0;
                            state_reg  <= ST_READ;
                        end
                        else
                        begin
                            state_reg <= ST_ADV;
                        end
                    end
                    else
                    begin
                        r_reg     <= SW'(fin_sat);
                        state_reg <= ST_ADV;
                    end
                end
                ST_ADV:
                begin
                    if (cfg.mono)
                    begin
                        l_reg <= SW'(mix_sum >>> 1);
                        r_reg <= SW'(mix_sum >>> 1);
                    end
                    newpos_reg <= adv_pos;
                    if (adv_pos >= (PW+1)'({cfg.len, {FW{1'b0}}}))
                    begin
                        if (cfg.loop_en)
                        begin
                            div_start_reg <= 1'b1;
                            div_num_reg   <= adv_pos[PW:FW];
                            state_reg     <= ST_WRAP;
                        end
                        else
                        begin
                            running_reg <= 1'b0;
                            pos_reg     <= adv_pos[PW-1:0];
                            state_reg   <= ST_OUT;
                        end
                    end
                    else
                    begin
                        pos_reg   <= adv_pos[PW-1:0];
                        state_reg <= ST_OUT;
                    end
                end
                ST_WRAP:
                begin
                    if (div_rsp.done)
                    begin
                        pos_reg   <= {div_rsp.rem, newpos_reg[FW-1:0]};
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (can_load)
                    begin
                        out_valid_reg <= 1'b1;
                        out_left_reg  <= l_reg;
                        out_right_reg <= r_reg;
                        out_run_reg   <= running_reg;
                        out_pos_reg   <= pos_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ===== src/looping_sample_player_cubic.sv =====
// -----------------------------------------------------------------------------
// looping_sample_player_cubic
// Looping sample player with 4-point cubic Lagrange interpolation.
// -----------------------------------------------------------------------------
// Items enter through a two-deep command queue, so the input side keeps
// taking items while the back end works and while a finished frame waits in
// the output register. Write, play and stop are handled in the idle state;
// seek takes one pass through the 18-step bit-serial remainder unit. A tick
// while stopped sends a silent frame. A running tick has the remainder unit
// find the sample index, then each channel needs four reads through the
// single memory read port and three passes through one shared multiplier,
// then one reciprocal multiply for the divide by six; a wrapped position
// takes one more pass through the remainder unit. A stalled output holds the
// finished frame and keeps the back end waiting. Sample memory holds two
// channels of MEM_DEPTH samples and is not cleared; read only samples that
// have been written. Configuration is always accepted (cfg_ready is tied
// high) and must be written only while the block is idle.
// -----------------------------------------------------------------------------
module looping_sample_player_cubic #(
    parameter int MEM_DEPTH = 65536
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // input channel
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [2:0]                           kind,
    input  logic                                 channel,
    input  logic [lspc_pkg::ADDR_W-1:0]          address,
    input  logic signed [lspc_pkg::SAMPLE_W-1:0] sample_value,
    input  logic [lspc_pkg::SEEK_W-1:0]          seek_position,
    // output channel
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [lspc_pkg::SAMPLE_W-1:0] out_left,
    output logic signed [lspc_pkg::SAMPLE_W-1:0] out_right,
    output logic                                 still_running,
    output logic [lspc_pkg::POS_W-1:0]           position_now,
    // configuration channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [lspc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [lspc_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int LW = lspc_pkg::LEN_W;

    lspc_pkg::push_t    push;
    lspc_pkg::cmd_t     q_head;
    lspc_pkg::cfg_t     cfg;
    lspc_pkg::div_req_t div_req;
    lspc_pkg::div_rsp_t div_rsp;
    logic               q_full;
    logic               q_empty;
    logic               q_pop;

    logic [lspc_pkg::RATE_W-1:0] rate_reg;
    logic [LW-1:0]               length_reg;
    logic                        loop_reg;
    logic                        stereo_reg;
    logic                        mono_reg;
    logic [LW-1:0]               eff_len;

    assign cfg_ready = 1'b1;

    // Configuration registers; an index past the list is dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg   <= lspc_pkg::RATE_RESET;
            length_reg <= lspc_pkg::LEN_RESET;
            loop_reg   <= 1'b0;
            stereo_reg <= 1'b0;
            mono_reg   <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                lspc_pkg::REG_RATE:   rate_reg   <= cfg_data[lspc_pkg::RATE_W-1:0];
                lspc_pkg::REG_LENGTH: length_reg <= cfg_data[LW-1:0];
                lspc_pkg::REG_LOOP:   loop_reg   <= cfg_data[0];
                lspc_pkg::REG_STEREO: stereo_reg <= cfg_data[0];
                lspc_pkg::REG_MONO:   mono_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Clamp the length to the range the memory can serve.
    always_comb
    begin
        if (length_reg < lspc_pkg::LEN_MIN)
        begin
            eff_len = lspc_pkg::LEN_MIN;
        end
        else if (32'(length_reg) > 32'(MEM_DEPTH))
        begin
            eff_len = LW'(MEM_DEPTH);
        end
        else
        begin
            eff_len = length_reg;
        end
        cfg.rate    = rate_reg;
        cfg.len     = eff_len;
        cfg.loop_en = loop_reg;
        cfg.stereo  = stereo_reg;
        cfg.mono    = mono_reg;
    end

    lspc_front u_front (
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .kind          (kind),
        .channel       (channel),
        .address       (address),
        .sample_value  (sample_value),
        .seek_position (seek_position),
        .q_full        (q_full),
        .push          (push)
    );

    lspc_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (q_pop),
        .full  (q_full),
        .empty (q_empty),
        .head  (q_head)
    );

    lspc_rem u_rem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    lspc_back #(
        .MEM_DEPTH (MEM_DEPTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .q_empty       (q_empty),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .div_req       (div_req),
        .div_rsp       (div_rsp),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_left      (out_left),
        .out_right     (out_right),
        .still_running (still_running),
        .position_now  (position_now)
    );

endmodule

// ===== src/lspc_checker.sv =====
// -----------------------------------------------------------------------------
// lspc_checker
// Port-level checks on the looping sample player, bound to the top level.
// -----------------------------------------------------------------------------
`include "looping_sample_player_cubic_defines.svh"

module lspc_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 out_valid,
    input logic                                 out_stall,
    input logic signed [lspc_pkg::SAMPLE_W-1:0] out_left,
    input logic signed [lspc_pkg::SAMPLE_W-1:0] out_right,
    input logic                                 still_running,
    input logic [lspc_pkg::POS_W-1:0]           position_now,
    input logic                                 cfg_valid,
    input logic                                 cfg_ready
);

    // hold a stalled frame
    `LSPC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_left) && $stable(out_right) && $stable(still_running) && $stable(position_now))

    // configuration is never back-pressured
    `LSPC_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready)

    // no frame is shown while reset is held
    `LSPC_ASSERT_ALWAYS(a_reset_quiet, !rst_n, out_valid !== 1'b1)

endmodule

bind looping_sample_player_cubic lspc_checker u_lspc_checker (.*);

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// tb: looping sample player regression
// Drives write, tick, play, stop, seek and unused-kind transactions with random gaps on
// both channels, predicts every frame with a bit-exact cubic interpolator
// and compares each output transaction field by field.
// -----------------------------------------------------------------------------

// Expected contents of one output transaction
typedef struct {
    logic signed [lspc_pkg::SAMPLE_W-1:0] left;
    logic signed [lspc_pkg::SAMPLE_W-1:0] right;
    logic                                 run;
    logic [lspc_pkg::POS_W-1:0]           pos;
} frame_t;

class player_scoreboard;
    localparam int DEPTH = 65536;
    localparam longint POS_MASK = (64'd1 << lspc_pkg::POS_W) - 1;

    shortint sample_mem [2][DEPTH];
    bit      written    [2][DEPTH];
    longint  play_pos;
    bit      playing;
    longint  rate;
    longint  len_reg;
    bit      loop_en;
    bit      stereo;
    bit      mono;
    frame_t  frames_due[$];
    int      errors;
    int      frames_seen;

    function new();
        play_pos = 0;
        playing  = 0;
        rate     = 65536;
        len_reg  = 4;
        loop_en  = 0;
        stereo   = 0;
        mono     = 0;
        errors   = 0;
        frames_seen = 0;
    endfunction

    function void set_reg(logic [lspc_pkg::CFG_IDX_W-1:0] idx, longint val);
        case (idx)
            lspc_pkg::REG_RATE:   rate    = val & 64'h7FFFF;
            lspc_pkg::REG_LENGTH: len_reg = val & 64'h1FFFF;
            lspc_pkg::REG_LOOP:   loop_en = val[0];
            lspc_pkg::REG_STEREO: stereo  = val[0];
            lspc_pkg::REG_MONO:   mono    = val[0];
            default: ;
        endcase
    endfunction

    function longint eff_len();
        if (len_reg < 4) return 4;
        if (len_reg > DEPTH) return DEPTH;
        return len_reg;
    endfunction

    // Memory index of neighbor k (0..3 = index-1 .. index+2) at the current position
    function int neighbor(int k);
        longint n;
        longint im;
        n  = eff_len();
        im = (play_pos >> lspc_pkg::FRAC_W) % n;
        return int'((im + n - 1 + k) % n);
    endfunction

    function longint cubic(int ch);
        longint y0, y1, y2, y3, a, b, c, t, f, q;
        y0 = sample_mem[ch][neighbor(0)];
        y1 = sample_mem[ch][neighbor(1)];
        y2 = sample_mem[ch][neighbor(2)];
        y3 = sample_mem[ch][neighbor(3)];
        f  = play_pos & 64'hFFFF;
        a  = -y0 + 3 * y1 - 3 * y2 + y3;
        b  = 3 * y0 - 6 * y1 + 3 * y2;
        c  = -2 * y0 - 3 * y1 + 6 * y2 - y3;
        // round to nearest, ties up: floor((x + half) / 2^16)
        t  = (a * f + 32768) >>> 16;
        t  = ((t + b) * f + 32768) >>> 16;
        t  = ((t + c) * f + 32768) >>> 16;
        t  = t + 3;
        q  = t / 6;
        if ((t % 6) != 0 && t < 0) q = q - 1;
        q = y1 + q;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return q;
    endfunction

    function void note_input(logic [2:0] kind, logic ch, logic [15:0] addr,
                             logic signed [15:0] val, logic [31:0] seek);
        frame_t fr;
        longint l, r, s, nxt, lenf;
        lenf = eff_len() << lspc_pkg::FRAC_W;
        case (kind)
            lspc_pkg::OP_WRITE:
            begin
                sample_mem[ch][addr] = val;
                written[ch][addr]    = 1;
            end
            lspc_pkg::OP_PLAY: playing = 1;
            lspc_pkg::OP_STOP: playing = 0;
            lspc_pkg::OP_SEEK: play_pos = longint'(seek) % lenf;
            lspc_pkg::OP_TICK:
            begin
                l = 0;
                r = 0;
                if (playing) begin
                    l = cubic(0);
                    r = stereo ? cubic(1) : l;
                    if (mono) begin
                        s = l + r;
                        l = s >>> 1;
                        r = l;
                    end
                    nxt = play_pos + rate;
                    if (nxt >= lenf) begin
                        if (loop_en) nxt = nxt % lenf;
                        else playing = 0;
                    end
                    play_pos = nxt & POS_MASK;
                end
                fr.left  = l[15:0];
                fr.right = r[15:0];
                fr.run   = playing;
                fr.pos   = play_pos[lspc_pkg::POS_W-1:0];
                frames_due.push_back(fr);
            end
            default: ;
        endcase
    endfunction

    function void check_result(logic signed [15:0] l, logic signed [15:0] r, logic run,
                               logic [lspc_pkg::POS_W-1:0] pos);
        frame_t exp_fr;
        frames_seen++;
        if (frames_due.size() == 0) begin
            $error("output transaction with no frame due");
            errors++;
            return;
        end
        exp_fr = frames_due.pop_front();
        if (l !== exp_fr.left) begin
            $error("out_left expected %0d actual %0d", exp_fr.left, l);
            errors++;
        end
        if (r !== exp_fr.right) begin
            $error("out_right expected %0d actual %0d", exp_fr.right, r);
            errors++;
        end
        if (run !== exp_fr.run) begin
            $error("still_running expected %0d actual %0d", exp_fr.run, run);
            errors++;
        end
        if (pos !== exp_fr.pos) begin
            $error("position_now expected %h actual %h", exp_fr.pos, pos);
            errors++;
        end
    endfunction
endclass

module tb;

    localparam int     CYCLE_LIMIT = 4000000;
    localparam int     SETTLE      = 200;    // covers a seek plus queued work
    localparam logic [2:0] KIND_SPARE = 3'd5; // first unused kind code

    logic                  clk = 0;
    logic                  rst_n = 0;
    logic                  in_valid = 0;
    logic                  in_stall;
    logic [2:0]            kind = lspc_pkg::OP_WRITE;
    logic                  channel = 0;
    logic [lspc_pkg::ADDR_W-1:0]          address = '0;
    logic signed [lspc_pkg::SAMPLE_W-1:0] sample_value = '0;
    logic [lspc_pkg::SEEK_W-1:0]          seek_position = '0;
    logic                  out_valid;
    logic                  out_stall = 0;
    logic signed [lspc_pkg::SAMPLE_W-1:0] out_left;
    logic signed [lspc_pkg::SAMPLE_W-1:0] out_right;
    logic                  still_running;
    logic [lspc_pkg::POS_W-1:0]           position_now;
    logic                  cfg_valid = 0;
    logic                  cfg_ready;
    logic [lspc_pkg::CFG_IDX_W-1:0]       cfg_index = '0;
    logic [lspc_pkg::CFG_DATA_W-1:0]      cfg_data = '0;

    looping_sample_player_cubic dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .kind          (kind),
        .channel       (channel),
        .address       (address),
        .sample_value  (sample_value),
        .seek_position (seek_position),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_left      (out_left),
        .out_right     (out_right),
        .still_running (still_running),
        .position_now  (position_now),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    player_scoreboard sb = new();

    int  send_idle_pct = 0;   // chance in percent that the sender idles before an item
    int  recv_idle_pct = 0;   // chance in percent that the receiver stalls a cycle
    bit  holdoff_req   = 0;   // ask the receiver for one long stall stretch
    int  cycles        = 0;
    int  items_sent    = 0;

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    // Abort the run if the block hangs
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Output side: check each accepted transaction, then pick the next stall.
    // The long hold-off is counted here so the sender keeps offering items.
    always @(posedge clk)
    begin : receiver
        int hold_cnt;
        bit hold_done;
        if (out_valid && !out_stall)
            sb.check_result(out_left, out_right, still_running, position_now);
        if (holdoff_req && !hold_done) begin
            hold_done = 1;
            hold_cnt  = 800;
        end
        if (hold_cnt > 0) begin
            hold_cnt  = hold_cnt - 1;
            out_stall <= 1'b1;
        end
        else begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Offer one input transaction and hold it until accepted
    task automatic send_item(logic [2:0] k, logic ch, logic [15:0] addr,
                             logic [15:0] val, logic [31:0] seek);
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
        in_valid      <= 1'b1;
        kind          <= k;
        channel       <= ch;
        address       <= addr;
        sample_value  <= val;
        seek_position <= seek;
        do @(posedge clk); while (in_stall);
        sb.note_input(k, ch, addr, val, seek);
        items_sent++;
    endtask

    task automatic send_write(int ch, int addr, logic [15:0] val);
        send_item(lspc_pkg::OP_WRITE, ch[0], addr[15:0], val, $urandom);
    endtask

    // Fill any unwritten neighbor the next running tick would read
    task automatic fill_neighbors();
        int idx;
        if (!sb.playing) return;
        for (int k = 0; k < 4; k++) begin
            for (int ch = 0; ch < 2; ch++) begin
                idx = sb.neighbor(k);
                if ((ch == 0 || sb.stereo) && !sb.written[ch][idx])
                    send_write(ch, idx, 16'($urandom));
            end
        end
    endtask

    task automatic send_tick();
        fill_neighbors();
        send_item(lspc_pkg::OP_TICK, 1'($urandom), 16'($urandom), 16'($urandom), $urandom);
    endtask

    task automatic write_reg(logic [lspc_pkg::CFG_IDX_W-1:0] idx,
                             logic [lspc_pkg::CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        sb.set_reg(idx, longint'(val));
        cfg_valid <= 1'b0;
    endtask

    // Drop input valid, wait out every frame due, then let the back end settle
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.frames_due.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic random_item();
        int pick;
        longint lenf;
        pick = $urandom_range(99);
        lenf = sb.eff_len() << lspc_pkg::FRAC_W;
        if (pick < 55)
            send_tick();
        else if (pick < 75)
            send_write(int'($urandom_range(1)),
                       ($urandom_range(3) == 0) ? int'($urandom_range(65535))
                                                : int'($urandom_range(32'(sb.eff_len() - 1))),
                       16'($urandom));
        else if (pick < 83)
            send_item(lspc_pkg::OP_PLAY, 1'($urandom), 16'($urandom), 16'($urandom),
                      $urandom);
        else if (pick < 86)
            send_item(lspc_pkg::OP_STOP, 1'($urandom), 16'($urandom), 16'($urandom),
                      $urandom);
        else if (pick < 96) begin
            // half the seeks land just before the end to exercise the wrap, if the length fits in 32 bits
            if ($urandom_range(1) && lenf <= 64'hFFFFFFFF)
                send_item(lspc_pkg::OP_SEEK, 1'($urandom), 16'($urandom), 16'($urandom),
                          32'(lenf - $urandom_range(200000, 1)));
            else
                send_item(lspc_pkg::OP_SEEK, 1'($urandom), 16'($urandom), 16'($urandom),
                          $urandom);
        end
        else
            send_item(KIND_SPARE + 3'($urandom_range(2)), 1'($urandom), 16'($urandom),
                      16'($urandom), $urandom);
    endtask

    initial
    begin : stimulus
        longint rates   [8] = '{65536, 0, 262144, 12345, 65536, 99999, 1, 200000};
        longint lengths [8] = '{4, 5, 4, 37, 65536, 0, 131071, 9};
        bit     loops   [8] = '{0, 1, 1, 1, 1, 0, 1, 0};
        bit     stereos [8] = '{0, 1, 1, 0, 1, 1, 0, 1};
        bit     monos   [8] = '{0, 0, 1, 1, 0, 1, 0, 1};
        logic [15:0] edge_vals [4] = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF};
        int phase_end;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset settings, extreme samples, every kind
        send_tick();                                     // tick while stopped
        for (int i = 0; i < 4; i++) send_write(0, i, edge_vals[i]);
        send_write(1, 65535, 16'h8000);                  // top address, channel one
        send_item(lspc_pkg::OP_PLAY, 0, 0, 0, 0);
        repeat (4) send_tick();                          // last one runs off the end
        send_item(lspc_pkg::OP_PLAY, 0, 0, 0, 0);
        send_tick();                                     // one frame past the end
        send_item(lspc_pkg::OP_SEEK, 0, 0, 0, 32'hFFFF_FFFF);
        send_item(lspc_pkg::OP_PLAY, 0, 0, 0, 0);
        send_tick();
        send_item(lspc_pkg::OP_SEEK, 1, 16'hFFFF, 16'hFFFF, 32'h0001_8000);
        send_tick();
        send_item(KIND_SPARE, 1, 16'hFFFF, 16'h7FFF, 32'hFFFF_FFFF);
        send_item(KIND_SPARE + 3'd2, 0, 0, 0, 0);
        send_item(lspc_pkg::OP_STOP, 0, 0, 0, 0);
        send_tick();
        drain();

        // Random phases across register settings; idling pattern rotates by thirds
        for (int ph = 0; ph < 8; ph++) begin
            if (ph < 3) begin
                send_idle_pct = 23;
                recv_idle_pct = 88;
            end
            else if (ph < 6) begin
                send_idle_pct = 88;
                recv_idle_pct = 23;
            end
            else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_reg(lspc_pkg::REG_RATE,   32'(rates[ph]));
            write_reg(lspc_pkg::REG_LENGTH, 32'(lengths[ph]));
            write_reg(lspc_pkg::REG_LOOP,   32'(loops[ph]));
            write_reg(lspc_pkg::REG_STEREO, 32'(stereos[ph]));
            write_reg(lspc_pkg::REG_MONO,   32'(monos[ph]));
            if (ph == 6) holdoff_req = 1;   // fill the block while output holds off
            phase_end = items_sent + 125;
            while (items_sent < phase_end) begin
                random_item();
            end
            drain();
        end

        $display("covered %0d input transactions, %0d frames, 8 register settings",
                 items_sent, sb.frames_seen);
        $display("with sender and receiver gaps and one long output hold-off");
        if (sb.errors == 0 && sb.frames_due.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+src
src/lspc_pkg.sv
src/lspc_front.sv
src/lspc_queue.sv
src/lspc_rem.sv
src/lspc_back.sv
src/looping_sample_player_cubic.sv
src/lspc_checker.sv
dv/tb.sv
